@@ src/i8ll_pkg.sv @@
package i8ll_pkg;

  localparam int WADDR_W = 12;
  localparam int WDEPTH = 1 << WADDR_W;
  localparam int OIDX_W = 6;
  localparam int CNT_W = 7;

  localparam logic [1:0] OP_LOAD_W = 2'd0;
  localparam logic [1:0] OP_LOAD_S = 2'd1;
  localparam logic [1:0] OP_LOAD_B = 2'd2;
  localparam logic [1:0] OP_ACT    = 2'd3;

  localparam logic [1:0] REG_IN_COUNT    = 2'd0;
  localparam logic [1:0] REG_OUT_COUNT   = 2'd1;
  localparam logic [1:0] REG_BIAS_ENABLE = 2'd2;

  typedef struct packed {
    logic              accept;
    logic              mac_start;
    logic              mac_issue;
    logic              fin_mul;
    logic              fin_sum;
    logic              fin_rnd;
    logic              fin_load;
    logic              fin_last;
    logic              clear_acc;
    logic [OIDX_W-1:0] o;
  } cmd_t;

  typedef struct packed {
    logic             act_ok;
    logic             act_last;
    logic [CNT_W-1:0] nout;
    logic             drained;
    logic             out_free;
  } sts_t;

endpackage

@@ src/i8ll_ctrl.sv @@
module i8ll_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  i8ll_pkg::sts_t      sts,
  output i8ll_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_RND   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state, state_next;
  logic [i8ll_pkg::OIDX_W-1:0] o, o_next;
  logic row_end, row_end_next;
  logic at_last;

  assign in_stall = (state != S_IDLE);
  assign at_last = ({1'b0, o} == (sts.nout - 7'd1));

  always_comb begin
    state_next = state;
    o_next = o;
    row_end_next = row_end;
    cmd = '0;
    cmd.o = o;
    case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && sts.act_ok) begin
          cmd.mac_start = 1'b1;
          row_end_next = sts.act_last;
          o_next = '0;
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (at_last) begin
          o_next = '0;
          state_next = S_DRAIN;
        end else begin
          o_next = o + 1'b1;
        end
      end
      S_DRAIN: begin
        if (sts.drained) begin
          state_next = row_end ? S_RD : S_IDLE;
        end
      end
      S_RD: state_next = S_MUL;
      S_MUL: begin
        cmd.fin_mul = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.fin_sum = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.fin_rnd = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.fin_load = 1'b1;
          cmd.fin_last = at_last;
          if (at_last) begin
            cmd.clear_acc = 1'b1;
            o_next = '0;
            state_next = S_IDLE;
          end else begin
            o_next = o + 1'b1;
            state_next = S_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      o <= '0;
      row_end <= 1'b0;
    end else begin
      state <= state_next;
      o <= o_next;
      row_end <= row_end_next;
    end
  end

endmodule

@@ src/i8ll_dp.sv @@
module i8ll_dp #(
  parameter int MAX_IN = 64,
  parameter int MAX_OUT = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data,
  input  logic [1:0]          opcode,
  input  logic [11:0]         index,
  input  logic signed [31:0]  value,
  input  i8ll_pkg::cmd_t      cmd,
  output i8ll_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_value,
  output logic [5:0]          out_index,
  output logic                last
);

  localparam int OW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;

  logic [6:0] in_count, out_count;
  logic bias_en;
  logic [6:0] nin, nout;

  logic [7:0]  wmem [i8ll_pkg::WDEPTH];
  logic [15:0] smem [MAX_OUT];
  logic [31:0] bmem [MAX_OUT];
  logic [47:0] amem [MAX_OUT];
  logic [MAX_OUT-1:0] avalid;

  logic [OW-1:0] ra;
  logic [11:0] maddr;
  logic signed [15:0] x;
  logic signed [7:0] w_q;
  logic signed [15:0] s_q;
  logic [31:0] b_q;
  logic [47:0] a_q;
  logic av_q;
  logic p1, p2;
  logic [OW-1:0] o1, o2;
  logic signed [23:0] mprod, prod2;
  logic [47:0] accv, acc2;

  logic signed [23:0] acc_hi;
  logic signed [39:0] hi_m, hi_p;
  logic signed [40:0] lo_m, lo_p;
  logic [31:0] bias_r;
  logic signed [63:0] fsum, rnd, fy;
  logic signed [31:0] sat;
  logic ld_ok;

  assign ra = cmd.o[OW-1:0];

  always_comb begin
    if (in_count == 7'd0) begin
      nin = 7'd1;
    end else if ({6'd0, in_count} > 13'(MAX_IN)) begin
      nin = 7'(MAX_IN);
    end else begin
      nin = in_count;
    end
    if (out_count == 7'd0) begin
      nout = 7'd1;
    end else if (out_count > 7'(MAX_OUT)) begin
      nout = 7'(MAX_OUT);
    end else begin
      nout = out_count;
    end
  end

  assign ld_ok = (index < 12'(MAX_OUT));
  assign sts.act_ok = (opcode == i8ll_pkg::OP_ACT) && (index < {5'd0, nin});
  assign sts.act_last = (index == {5'd0, nin - 7'd1});
  assign sts.nout = nout;
  assign sts.drained = !p1 && !p2;
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_count <= 7'd64;
      out_count <= 7'd64;
      bias_en <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        i8ll_pkg::REG_IN_COUNT:    in_count <= cfg_data;
        i8ll_pkg::REG_OUT_COUNT:   out_count <= cfg_data;
        i8ll_pkg::REG_BIAS_ENABLE: bias_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && opcode == i8ll_pkg::OP_LOAD_W) begin
      wmem[index] <= value[7:0];
    end
    w_q <= wmem[maddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && opcode == i8ll_pkg::OP_LOAD_S && ld_ok) begin
      smem[index[OW-1:0]] <= value[15:0];
    end
    s_q <= smem[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && opcode == i8ll_pkg::OP_LOAD_B && ld_ok) begin
      bmem[index[OW-1:0]] <= value;
    end
    b_q <= bmem[ra];
  end

  always_ff @(posedge clk) begin
    if (p2) begin
      amem[o2] <= acc2 + {{24{prod2[23]}}, prod2};
    end
    a_q <= amem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avalid <= '0;
    end else if (cmd.clear_acc) begin
      avalid <= '0;
    end else if (p2) begin
      avalid[o2] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    av_q <= avalid[ra];
    if (cmd.mac_start) begin
      maddr <= index;
      x <= value[15:0];
    end else if (cmd.mac_issue) begin
      maddr <= maddr + {5'd0, nin};
    end
    o1 <= ra;
    o2 <= o1;
    prod2 <= mprod;
    acc2 <= accv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
    end else begin
      p1 <= cmd.mac_issue;
      p2 <= p1;
    end
  end

  assign mprod = x * w_q;
  assign accv = av_q ? a_q : 48'd0;

  assign acc_hi = accv[47:24];
  assign hi_m = acc_hi * s_q;
  assign lo_m = $signed({1'b0, accv[23:0]}) * s_q;
  assign rnd = (fsum + 64'sd8) >>> 4;

  always_ff @(posedge clk) begin
    if (cmd.fin_mul) begin
      hi_p <= hi_m;
      lo_p <= lo_m;
      bias_r <= bias_en ? b_q : 32'd0;
    end
    if (cmd.fin_sum) begin
      fsum <= ({{24{hi_p[39]}}, hi_p} << 24) + {{23{lo_p[40]}}, lo_p};
    end
    if (cmd.fin_rnd) begin
      fy <= rnd + {{32{bias_r[31]}}, bias_r};
    end
  end

  always_comb begin
    if (fy > 64'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (fy < -64'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = fy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      out_value <= sat;
      out_index <= cmd.o;
      last <= cmd.fin_last;
    end
  end

endmodule

@@ src/int8_weight_linear_layer.sv @@
// Quantised linear layer with int8 weights and a per-output scale and bias.
// Input channel (in_valid, in_stall, opcode, index, value): one beat is either a
// load of a weight, scale or bias, or one activation element of a row. A load
// does not stall the input. An activation element holds the input stalled until
// one shared multiply-accumulate unit has visited every output in turn and its
// pipeline has drained, so no new element is taken before the last is done. The
// element at index in_count - 1 (in_count held to 1..MAX_IN) ends the row; the
// block then produces out_count (held to 1..MAX_OUT) result beats on the output
// channel (out_valid, out_stall, out_value, out_index, last). For each output in
// turn the accumulator is scaled, rounded, biased and saturated, with last set
// on the final beat. The accumulators are cleared once the last result is loaded
// into the output register. The output register lets a waiting result sit while
// the next one is computed. If the receiver raises out_stall, the result is held
// and the sequence pauses until it is accepted; results are never dropped. The
// configuration port (cfg_write, cfg_index, cfg_data) sets in_count, out_count
// and bias_enable; the user must use it only while the block is idle, which the
// block itself does not enforce. A synchronous reset returns the registers to 64,
// 64 and 0, marks the accumulators empty and empties the output register; the
// weight, scale and bias memories hold whatever was last written.
module int8_weight_linear_layer #(
  parameter int MAX_IN = 64,
  parameter int MAX_OUT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [11:0]        index,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic [5:0]         out_index,
  output logic               last
);

  i8ll_pkg::cmd_t cmd;
  i8ll_pkg::sts_t sts;

  i8ll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  i8ll_dp #(
    .MAX_IN  (MAX_IN),
    .MAX_OUT (MAX_OUT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .opcode    (opcode),
    .index     (index),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_index (out_index),
    .last      (last)
  );

endmodule
